// ===== design/b2s_pkg.sv =====
// ----------------------------------------------------------------------------
// b2s_pkg: shared types and constants of the BLAKE2s-256 hash engine
// Holds the IV, the parameter word, the message schedule and FSM types.
// ----------------------------------------------------------------------------
`default_nettype none
package b2s_pkg;

    localparam int BLOCK_BYTES = 64;

    localparam logic [31:0] IV [0:7] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    // digest length 32, fanout 1, depth 1
    localparam logic [31:0] PARAM_WORD = 32'h01010020;

    localparam int ROUNDS = 10;

    localparam logic [3:0] SIGMA [0:9][0:15] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
    };

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_BYTE,
        TS_COMP,
        TS_OUT
    } t_top_state;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_INIT,
        CS_MIX,
        CS_DIAG,
        CS_UNDIAG,
        CS_FEED
    } t_cmp_state;

    typedef struct packed {
        logic start;
        logic final_blk;
        logic reinit;
    } t_cmp_ctl;

    function automatic logic [31:0] chain_init(input logic [2:0] idx);
        logic [31:0] w;
        w = IV[idx];
        if (idx == 3'd0) begin
            w = w ^ PARAM_WORD;
        end
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== design/b2s_gmix.sv =====
// ----------------------------------------------------------------------------
// b2s_gmix: half of the G mixing function
// First half uses rotations 16/12, second half 8/7.
// ----------------------------------------------------------------------------
`default_nettype none
module b2s_gmix (
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    input  wire logic [31:0] i_c,
    input  wire logic [31:0] i_d,
    input  wire logic [31:0] i_m,
    input  wire logic        i_half,
    output logic      [31:0] o_a,
    output logic      [31:0] o_b,
    output logic      [31:0] o_c,
    output logic      [31:0] o_d
);
    logic [31:0] w_dx;
    logic [31:0] w_bx;

    // add, xor, rotate in sequence
    always_comb begin
        o_a  = i_a + i_b + i_m;
        w_dx = i_d ^ o_a;
        o_d  = i_half ? {w_dx[7:0], w_dx[31:8]} : {w_dx[15:0], w_dx[31:16]};
        o_c  = i_c + o_d;
        w_bx = i_b ^ o_c;
        o_b  = i_half ? {w_bx[6:0], w_bx[31:7]} : {w_bx[11:0], w_bx[31:12]};
    end
endmodule
`default_nettype wire

// ===== design/b2s_compress.sv =====
// ----------------------------------------------------------------------------
// b2s_compress: compression sequencer around one shared half-G unit
// Work vector is kept as four rows; column 0 feeds the unit and rows rotate.
// ----------------------------------------------------------------------------
`default_nettype none
module b2s_compress
    import b2s_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmp_ctl    i_ctl,
    input  wire logic [63:0] i_counter,
    input  wire logic [31:0] i_msg_word,
    input  wire logic [2:0]  i_rd_idx,
    output logic      [3:0]  o_msg_idx,
    output logic             o_done,
    output logic      [31:0] o_chain_word
);
    t_cmp_state  r_state;
    t_cmp_state  n_state;
    logic [31:0] r_v [0:15];
    logic [31:0] r_h [0:7];
    logic [3:0]  r_round;
    logic        r_phase;
    logic [1:0]  r_g;
    logic        r_half;
    logic        r_final;
    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [31:0] w_c;
    logic [31:0] w_d;

    b2s_gmix u_gmix (
        .i_a    (r_v[0]),
        .i_b    (r_v[4]),
        .i_c    (r_v[8]),
        .i_d    (r_v[12]),
        .i_m    (i_msg_word),
        .i_half (r_half),
        .o_a    (w_a),
        .o_b    (w_b),
        .o_c    (w_c),
        .o_d    (w_d)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_IDLE:   if (i_ctl.start) n_state = CS_INIT;
            CS_INIT:   n_state = CS_MIX;
            CS_MIX: begin
                if (r_half && (r_g == 2'd3)) begin
                    n_state = r_phase ? CS_UNDIAG : CS_DIAG;
                end
            end
            CS_DIAG:   n_state = CS_MIX;
            CS_UNDIAG: n_state = (r_round == 4'(ROUNDS - 1)) ? CS_FEED : CS_MIX;
            CS_FEED:   n_state = CS_IDLE;
            default:   n_state = CS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_done       = (r_state == CS_FEED);
        o_msg_idx    = SIGMA[r_round][{r_phase, r_g, r_half}];
        o_chain_word = r_h[i_rd_idx];
    end

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_round <= '0;
            r_phase <= 1'b0;
            r_g     <= '0;
            r_half  <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                CS_IDLE: begin
                    r_final <= i_ctl.final_blk;
                    r_round <= '0;
                    r_phase <= 1'b0;
                    r_g     <= '0;
                    r_half  <= 1'b0;
                end
                CS_MIX: begin
                    r_half <= ~r_half;
                    if (r_half) begin
                        r_g <= r_g + 2'd1;
                    end
                end
                CS_DIAG: r_phase <= 1'b1;
                CS_UNDIAG: begin
                    r_phase <= 1'b0;
                    r_round <= r_round + 4'd1;
                end
                default: ;
            endcase
        end
    end

    // work vector datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            CS_INIT: begin
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= r_h[i];
                end
                for (int i = 0; i < 4; i++) begin
                    r_v[i + 8] <= IV[i];
                end
                r_v[12] <= IV[4] ^ i_counter[31:0];
                r_v[13] <= IV[5] ^ i_counter[63:32];
                r_v[14] <= r_final ? ~IV[6] : IV[6];
                r_v[15] <= IV[7];
            end
            CS_MIX: begin
                if (!r_half) begin
                    r_v[0]  <= w_a;
                    r_v[4]  <= w_b;
                    r_v[8]  <= w_c;
                    r_v[12] <= w_d;
                end else begin
                    // rotate each row left; new column goes to the end
                    for (int r = 0; r < 4; r++) begin
                        for (int c = 0; c < 3; c++) begin
                            r_v[r*4 + c] <= r_v[r*4 + c + 1];
                        end
                    end
                    r_v[3]  <= w_a;
                    r_v[7]  <= w_b;
                    r_v[11] <= w_c;
                    r_v[15] <= w_d;
                end
            end
            CS_DIAG: begin
                for (int r = 0; r < 4; r++) begin
                    for (int c = 0; c < 4; c++) begin
                        r_v[r*4 + c] <= r_v[r*4 + ((c + r) % 4)];
                    end
                end
            end
            CS_UNDIAG: begin
                for (int r = 0; r < 4; r++) begin
                    for (int c = 0; c < 4; c++) begin
                        r_v[r*4 + ((c + r) % 4)] <= r_v[r*4 + c];
                    end
                end
            end
            default: ;
        endcase
    end

    // chain value: reset, feed-forward, reload after digest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.reinit) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= chain_init(3'(i));
            end
        end else if (r_state == CS_FEED) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] ^ r_v[i] ^ r_v[i + 8];
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/blake2s_hash_engine.sv =====
// ----------------------------------------------------------------------------
// blake2s_hash_engine: unkeyed BLAKE2s-256 over a word stream
// Packs bytes into a 64-byte block and drives the compression sequencer.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis: data in tdata[31:0], valid byte count in
// tdata[34:32] (above four counts as four), tlast on the final word of a
// message. Each word is accepted, then its bytes enter the block buffer
// one per cycle while the block has room, then a closing step follows.
// When a byte finds the block full, the block is compressed first; a
// compression is launched, then runs init, 10 rounds of 16 half-G steps
// and two row shuffles, and feed-forward on the single shared half-G
// unit. s_axis_tready is low while bytes load, a block compresses or the
// digest drains.
// After the last word the final block is compressed and eight digest words
// leave on m_axis, word 0 first, index in tdata[34:32], tlast on word 7.
// A stall on m_axis holds the current word. After word 7 the engine is
// idle again with the IV reloaded and the byte counter cleared. Reset
// (synchronous, active low) loads the parameter-mixed IV and clears the
// buffer and the byte counter.
// ----------------------------------------------------------------------------
`default_nettype none
module blake2s_hash_engine
    import b2s_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // data_word[31:0], byte_count[34:32]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,  // digest_word[31:0], word_index[34:32]
    output logic             m_axis_tlast
);
    t_top_state  r_state;
    t_top_state  n_state;
    logic [31:0] r_msg [0:15];
    logic [31:0] r_word;
    logic [2:0]  r_cnt;
    logic [2:0]  r_bidx;
    logic        r_last;
    logic [6:0]  r_fill;
    logic [63:0] r_bcnt;
    logic [2:0]  r_oidx;
    logic        w_more;
    logic        w_full;
    logic        w_wr;
    t_cmp_ctl    w_ctl;
    logic [3:0]  w_msg_idx;
    logic        w_done;
    logic [31:0] w_chain;
    logic [5:0]  w_pos;

    assign w_more = (r_bidx < r_cnt);
    assign w_full = r_fill[6];
    assign w_pos  = r_fill[5:0];

    b2s_compress u_compress (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_counter    (r_bcnt),
        .i_msg_word   (r_msg[w_msg_idx]),
        .i_rd_idx     (r_oidx),
        .o_msg_idx    (w_msg_idx),
        .o_done       (w_done),
        .o_chain_word (w_chain)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TS_IDLE: if (s_axis_tvalid) n_state = TS_BYTE;
            TS_BYTE: begin
                priority if (w_more) begin
                    n_state = w_full ? TS_COMP : TS_BYTE;
                end else if (r_last) begin
                    n_state = TS_COMP;
                end else begin
                    n_state = TS_IDLE;
                end
            end
            TS_COMP: if (w_done) n_state = r_last && !w_more ? TS_OUT : TS_BYTE;
            TS_OUT:  if (m_axis_tready && (r_oidx == 3'd7)) n_state = TS_IDLE;
            default: n_state = TS_IDLE;
        endcase
    end

    // outputs and strobes
    always_comb begin
        s_axis_tready   = (r_state == TS_IDLE);
        m_axis_tvalid   = (r_state == TS_OUT);
        m_axis_tdata    = {5'd0, r_oidx, w_chain};
        m_axis_tlast    = (r_oidx == 3'd7);
        w_ctl.start     = (r_state == TS_BYTE) && ((w_more && w_full) || (!w_more && r_last));
        w_ctl.final_blk = !w_more;
        w_ctl.reinit    = (r_state == TS_OUT) && m_axis_tready && (r_oidx == 3'd7);
        w_wr            = (r_state == TS_BYTE) && w_more && !w_full;
    end

    // control and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TS_IDLE;
            r_fill  <= '0;
            r_bcnt  <= '0;
            r_oidx  <= '0;
            r_bidx  <= '0;
            r_cnt   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_axis_tvalid && s_axis_tready) begin
                r_cnt  <= (s_axis_tdata[34:32] > 3'd4) ? 3'd4 : s_axis_tdata[34:32];
                r_last <= s_axis_tlast;
                r_bidx <= '0;
            end
            if (w_wr) begin
                r_bidx <= r_bidx + 3'd1;
                r_fill <= r_fill + 7'd1;
            end
            // count the held bytes as the block goes out
            if (w_ctl.start) begin
                r_bcnt <= r_bcnt + {57'd0, r_fill};
            end
            if (w_done) begin
                r_fill <= '0;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                r_oidx <= r_oidx + 3'd1;
            end
            if (w_ctl.reinit) begin
                r_bcnt <= '0;
            end
        end
    end

    // word latch
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_word <= s_axis_tdata[31:0];
        end
    end

    // block buffer: byte-lane writes, clear after each compression
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_done) begin
            for (int i = 0; i < 16; i++) begin
                r_msg[i] <= '0;
            end
        end else if (w_wr) begin
            r_msg[w_pos[5:2]][8*w_pos[1:0] +: 8] <= r_word[8*r_bidx[1:0] +: 8];
        end
    end
endmodule
`default_nettype wire

// ===== design/b2s_checker.sv =====
// ----------------------------------------------------------------------------
// b2s_checker: port-level checks of the hash engine
// Watches the stream handshakes and the digest word sequence.
// ----------------------------------------------------------------------------
`default_nettype none
module b2s_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    // hold a stalled digest word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("digest word changed under stall");

    // never take input while the digest drains
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted during digest output");

    // tlast marks index seven
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
        else $error("tlast does not match word index");

    // indices advance by one
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
        else $error("digest word index skipped");

    // back to accepting input after the last word
    a_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("engine did not return to idle");
endmodule

bind blake2s_hash_engine b2s_checker u_b2s_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
